FILE: design/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// shared types and constants for the integer to radix digits converter
// ----------------------------------------------------------------------------
package itrd_pkg;

    // config port geometry: 64-bit registers at byte addresses 8*i
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam int REG_IDX_W = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_BASE_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

    // alphabet geometry
    localparam int BASE_W      = 5;
    localparam int ALPHA_N     = 16;
    localparam int ALPHA_IDX_W = 4;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS = 8;

    // special characters
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    // configuration register file contents
    typedef struct packed {
        logic [BASE_W-1:0] base_length;
        logic [63:0]       digits_low;
        logic [63:0]       digits_high;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic advance;
        logic emit_sign;
        logic emit_digit;
        logic emit_invalid;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic quo_zero;
        logic cnt_zero;
    } t_dp_sts;

endpackage

FILE: design/itrd_ram.sv
// ----------------------------------------------------------------------------
// itrd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module itrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/itrd_regs.sv
// ----------------------------------------------------------------------------
// itrd_regs
// apb configuration registers: radix and the 16-character alphabet
// ----------------------------------------------------------------------------
module itrd_regs
    import itrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    // register index from the 8-byte aligned address
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BASE_LENGTH: r_cfg.base_length <= pwdata[BASE_W-1:0];
                REG_DIGITS_LOW:  r_cfg.digits_low  <= pwdata;
                REG_DIGITS_HIGH: r_cfg.digits_high <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_BASE_LENGTH: prdata = PDATA_W'(r_cfg.base_length);
            REG_DIGITS_LOW:  prdata = r_cfg.digits_low;
            REG_DIGITS_HIGH: prdata = r_cfg.digits_high;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl
// conversion sequencer: divide loop, sign and digit emission, invalid result
// ----------------------------------------------------------------------------
module itrd_ctrl
    import itrd_pkg::*;
#(
    parameter int CHUNKS = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    localparam int CK_W = $clog2(CHUNKS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV     = 3'd1;
    localparam logic [2:0] ST_FETCH   = 3'd2;
    localparam logic [2:0] ST_OUT     = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CK_W-1:0] r_chunk, n_chunk;

    // next state and command decode
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_chunk = r_chunk;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_chunk    = '0;
                    n_state    = i_sts.alpha_ok ? ST_DIV : ST_INVALID;
                end
            end
            ST_DIV: begin
                // the quotient is only whole between digits, at chunk zero
                if (r_chunk == '0 && !i_sts.cnt_zero && i_sts.quo_zero) begin
                    n_state = ST_FETCH;
                end else begin
                    o_cmd.step = 1'b1;
                    if (r_chunk == CK_W'(CHUNKS - 1)) begin
                        o_cmd.store = 1'b1;
                        n_chunk     = '0;
                    end else begin
                        n_chunk = r_chunk + CK_W'(1);
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.emit_sign = i_sts.neg;
                o_cmd.advance   = 1'b1;
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_INVALID: begin
                o_cmd.emit_invalid = 1'b1;
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chunk <= '0;
        end else begin
            r_state <= n_state;
            r_chunk <= n_chunk;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: design/itrd_dp.sv
// ----------------------------------------------------------------------------
// itrd_dp
// datapath: magnitude, radix divider, digit stack and character output
// ----------------------------------------------------------------------------
module itrd_dp
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic [VALUE_BITS-1:0] i_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_valid,
    output logic [7:0]            o_text_char,
    output logic                  o_is_last,
    output logic                  o_is_invalid
);

    localparam int DIG_W  = $clog2(MAX_RADIX);
    localparam int T_W    = DIG_W + 1;
    localparam int CHUNKS = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W  = CHUNKS * DIV_STEPS;
    localparam int CW     = $clog2(VALUE_BITS + 1);
    localparam int AW     = $clog2(VALUE_BITS);

    logic [DIV_W-1:0]      r_quo, n_quo;
    logic [DIG_W-1:0]      r_rem, n_rem;
    logic [T_W-1:0]        r_radix;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] mag;
    logic [DIG_W-1:0]      rd_digit;
    logic [7:0]            alpha [ALPHA_N];
    logic                  bad;
    logic [T_W-1:0]        t;

    // alphabet as a byte array
    always_comb begin
        for (int k = 0; k < ALPHA_N / 2; k++) begin
            alpha[k]               = i_cfg.digits_low[8*k +: 8];
            alpha[k + ALPHA_N / 2] = i_cfg.digits_high[8*k +: 8];
        end
    end

    // alphabet check: radix range, sign characters, repeated characters
    always_comb begin
        bad = (i_cfg.base_length < BASE_W'(2)) || (i_cfg.base_length > BASE_W'(MAX_RADIX));
        for (int i = 0; i < ALPHA_N; i++) begin
            if (BASE_W'(i) < i_cfg.base_length) begin
                if (alpha[i] == CHAR_PLUS || alpha[i] == CHAR_MINUS) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < ALPHA_N; j++) begin
                    if (BASE_W'(j) < i_cfg.base_length && alpha[i] == alpha[j]) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    // magnitude of the two's complement input, most negative maps to 2^(n-1)
    assign mag = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    // one chunk of restoring division by the radix, quotient shifts in from the bottom
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        t     = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            t     = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (t >= r_radix) begin
                n_rem    = DIG_W'(t - r_radix);
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[DIG_W-1:0];
            end
        end
    end

    // operand and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= DIV_W'(mag);
            r_rem   <= '0;
            r_neg   <= i_value[VALUE_BITS-1];
            r_radix <= T_W'(i_cfg.base_length);
        end else if (i_cmd.step) begin
            r_quo <= n_quo;
            r_rem <= i_cmd.store ? '0 : n_rem;
        end
    end

    // digit count: write pointer while dividing, read pointer while emitting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.store) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.advance) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // digit stack, least significant digit at address 0
    itrd_ram #(
        .WIDTH (DIG_W),
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (n_rem),
        .i_raddr (AW'(r_cnt - CW'(1))),
        .o_rdata (rd_digit)
    );

    // status to the controller
    assign o_sts.alpha_ok = ~bad;
    assign o_sts.neg      = r_neg;
    assign o_sts.quo_zero = (r_quo == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);

    // result transaction
    assign o_valid      = i_cmd.emit_sign | i_cmd.emit_digit | i_cmd.emit_invalid;
    assign o_is_last    = (i_cmd.emit_digit & o_sts.cnt_zero) | i_cmd.emit_invalid;
    assign o_is_invalid = i_cmd.emit_invalid;

    always_comb begin
        if (i_cmd.emit_sign) begin
            o_text_char = CHAR_MINUS;
        end else if (i_cmd.emit_digit) begin
            o_text_char = alpha[ALPHA_IDX_W'(rd_digit)];
        end else begin
            o_text_char = CHAR_NONE;
        end
    end

`ifndef SYNTHESIS
    // at most one kind of result per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.emit_sign, i_cmd.emit_digit, i_cmd.emit_invalid}))
        else $error("itrd_dp: more than one result kind in a cycle");

    // digit stack never overflows
    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_cnt < CW'(VALUE_BITS)))
        else $error("itrd_dp: digit stack overflow");

    // no digit follows the last digit of a conversion
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_digit && r_cnt == '0) |=> !i_cmd.emit_digit)
        else $error("itrd_dp: digit emitted after the last one");
`endif

endmodule

FILE: design/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// converts a signed integer to its text in a configured radix and alphabet
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ----------------------------------
// input     in         start & !busy             i_value
// result    out        o_valid (one cycle)       o_text_char, o_is_last, o_is_invalid
// config    in         apb psel/penable/pwrite   paddr, pwdata (prdata on reads)
//
// busy stays high through a conversion; each digit takes C = ceil(VALUE_BITS/8) divider chunks,
// as the divider resolves 8 quotient bits per cycle
// any minus sign goes out in the cycle before the first digit, then one digit per cycle
// an unusable alphabet gives one invalid result in the cycle after the transaction
// reset is synchronous and active low; the receiver cannot stall, so nothing backs up
//
module integer_to_radix_digits
    import itrd_pkg::*;
#(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    output logic [7:0]                   o_text_char,
    output logic                         o_is_last,
    output logic                         o_is_invalid,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready
);

    localparam int CHUNKS = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // configuration registers
    itrd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    itrd_ctrl #(
        .CHUNKS (CHUNKS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath
    itrd_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_text_char  (o_text_char),
        .o_is_last    (o_is_last),
        .o_is_invalid (o_is_invalid)
    );

endmodule
